@@ design/ppmfb_pkg.sv @@
// Shared types and constants for the PPM stream to framebuffer decoder.
package ppmfb_pkg;

  localparam int MAX_DIM_DEF = 4096;
  localparam int FB_W = 13;
  localparam int ADDR_W = 24;
  localparam int ACC_W = 16;

  localparam logic [FB_W-1:0] FB_WIDTH_RST = 13'd1024;
  localparam logic [FB_W-1:0] FB_HEIGHT_RST = 13'd768;

  localparam logic [1:0] REG_FB_WIDTH = 2'd0;
  localparam logic [1:0] REG_FB_HEIGHT = 2'd1;

  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_SIX = 8'h36;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] FULL_SCALE = 8'd255;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_MAGIC   = 3'd1,
    ERR_VERSION = 3'd2,
    ERR_MAXVAL  = 3'd3,
    ERR_DIM     = 3'd4
  } err_t;

  typedef struct packed {
    logic clear;
    logic magic_scan;
    logic scan;
    logic set_bin;
    logic bin_val;
    logic ld_width;
    logic ld_height;
    logic start_div;
    logic raster_init;
    logic div_step;
    logic sample_bin;
    logic sample_tok;
    logic emit_err;
    err_t err_code;
    logic emit_done;
  } cmd_t;

  typedef struct packed {
    logic cmt;
    logic tok_end;
    logic tok_big;
    logic tok_zero;
    logic tok_over;
    logic bin;
    logic dims_zero;
    logic last_px;
    logic out_busy;
  } status_t;

endpackage

@@ design/ppmfb_ctrl.sv @@
// Parse-phase controller: header sequencing, divider control and input flow.
module ppmfb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_byte_value,
  input  logic              in_start_of_file,
  output logic              in_stall,
  input  ppmfb_pkg::status_t st,
  output ppmfb_pkg::cmd_t   cmd
);

  typedef enum logic [3:0] {
    PH_MAGIC_P, PH_MAGIC_D, PH_WIDTH, PH_HEIGHT, PH_MAXVAL,
    PH_DIV, PH_POST, PH_RASTER, PH_IDLE
  } phase_t;

  phase_t     state_r, state_nxt, ph;
  logic [2:0] cnt_r, cnt_nxt;
  logic       acc;
  logic       busy;
  logic       digit;

  assign busy = (state_r == PH_DIV) || (state_r == PH_POST);
  assign in_stall = busy || st.out_busy;
  assign acc = in_valid && !in_stall;
  assign digit = (in_byte_value >= ppmfb_pkg::CH_ZERO) && (in_byte_value <= ppmfb_pkg::CH_NINE);

  always_comb begin
    cmd = '0;
    cmd.err_code = ppmfb_pkg::ERR_NONE;
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    ph = in_start_of_file ? PH_MAGIC_P : state_r;
    if (state_r == PH_DIV) begin
      cmd.div_step = 1'b1;
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) state_nxt = PH_POST;
    end else if (state_r == PH_POST) begin
      if (st.dims_zero) begin
        if (!st.out_busy) begin
          cmd.emit_done = 1'b1;
          state_nxt = PH_IDLE;
        end
      end else begin
        state_nxt = PH_RASTER;
      end
    end else if (acc) begin
      cmd.clear = in_start_of_file;
      state_nxt = ph;
      case (ph)
        PH_MAGIC_P: begin
          cmd.magic_scan = 1'b1;
          if (!st.cmt && in_byte_value != ppmfb_pkg::CH_HASH) begin
            if (in_byte_value == ppmfb_pkg::CH_P) begin
              state_nxt = PH_MAGIC_D;
            end else begin
              cmd.emit_err = 1'b1;
              cmd.err_code = ppmfb_pkg::ERR_MAGIC;
              state_nxt = PH_IDLE;
            end
          end
        end
        PH_MAGIC_D: begin
          if (in_byte_value == ppmfb_pkg::CH_THREE || in_byte_value == ppmfb_pkg::CH_SIX) begin
            cmd.set_bin = 1'b1;
            cmd.bin_val = (in_byte_value == ppmfb_pkg::CH_SIX);
            state_nxt = PH_WIDTH;
          end else begin
            cmd.emit_err = 1'b1;
            cmd.err_code = digit ? ppmfb_pkg::ERR_VERSION : ppmfb_pkg::ERR_MAGIC;
            state_nxt = PH_IDLE;
          end
        end
        PH_WIDTH, PH_HEIGHT: begin
          cmd.scan = 1'b1;
          if (st.tok_end) begin
            if (st.tok_big) begin
              cmd.emit_err = 1'b1;
              cmd.err_code = ppmfb_pkg::ERR_DIM;
              state_nxt = PH_IDLE;
            end else if (ph == PH_WIDTH) begin
              cmd.ld_width = 1'b1;
              state_nxt = PH_HEIGHT;
            end else begin
              cmd.ld_height = 1'b1;
              state_nxt = PH_MAXVAL;
            end
          end
        end
        PH_MAXVAL: begin
          cmd.scan = 1'b1;
          if (st.tok_end) begin
            if (st.tok_zero || st.tok_over) begin
              cmd.emit_err = 1'b1;
              cmd.err_code = ppmfb_pkg::ERR_MAXVAL;
              state_nxt = PH_IDLE;
            end else begin
              cmd.start_div = 1'b1;
              cmd.raster_init = 1'b1;
              cnt_nxt = 3'd0;
              state_nxt = PH_DIV;
            end
          end
        end
        PH_RASTER: begin
          if (st.bin) begin
            cmd.sample_bin = 1'b1;
            if (st.last_px) state_nxt = PH_IDLE;
          end else begin
            cmd.scan = 1'b1;
            if (st.tok_end) begin
              cmd.sample_tok = 1'b1;
              if (st.last_px) state_nxt = PH_IDLE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PH_MAGIC_P;
      cnt_r <= 3'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ design/ppmfb_dp.sv @@
// Datapath: token scanner, header registers, scale divider, pixel packing and output word.
module ppmfb_dp #(
  parameter int MAX_DIM = ppmfb_pkg::MAX_DIM_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [7:0]                   in_byte_value,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [ppmfb_pkg::FB_W-1:0]   cfg_data,
  input  ppmfb_pkg::cmd_t              cmd,
  output ppmfb_pkg::status_t           st,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic [1:0]                   out_result_kind,
  output logic [ppmfb_pkg::ADDR_W-1:0] out_write_address,
  output logic [23:0]                  out_pixel_word,
  output logic [2:0]                   out_error_code
);

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int CW = ((DW > ppmfb_pkg::FB_W) ? DW : ppmfb_pkg::FB_W) + 1;
  localparam int MW = DW + ppmfb_pkg::FB_W;
  localparam int AW = ppmfb_pkg::ACC_W;

  logic [ppmfb_pkg::FB_W-1:0] fbw_r, fbh_r;
  logic          bin_r, bin_nxt, cmt_r, cmt_nxt, num_r, num_nxt;
  logic [DW-1:0] w_r, w_nxt, h_r, h_nxt, col_r, col_nxt, row_r, row_nxt;
  logic [7:0]    scale_r, scale_nxt, red_r, red_nxt, grn_r, grn_nxt;
  logic [7:0]    divd_r, divd_nxt, rem_r, rem_nxt;
  logic [AW-1:0] acc_r, acc_nxt;
  logic [1:0]    chan_r, chan_nxt;
  logic          ov_r, ov_nxt;
  logic [1:0]    ok_r, ok_nxt;
  logic [23:0]   oa_r, oa_nxt, op_r, op_nxt;
  logic [2:0]    oe_r, oe_nxt;

  logic          cmt_e, num_e, bin_e;
  logic [AW-1:0] acc_e;
  logic [1:0]    chan_e;
  logic [DW-1:0] col_e, row_e, w_e, h_e;
  logic [7:0]    scale_e, red_e, grn_e;
  logic          digit, nl;
  logic [3:0]    dval;
  logic [AW+3:0] mul10;
  logic [8:0]    trial;
  logic [7:0]    smp;
  logic [15:0]   sprod;
  logic [7:0]    sc;
  logic [MW-1:0] rowmul;
  logic [23:0]   addr, word;
  logic          fb_hit, last;
  logic [DW:0]   col1, row1;

  assign digit = (in_byte_value >= ppmfb_pkg::CH_ZERO) && (in_byte_value <= ppmfb_pkg::CH_NINE);
  assign nl = (in_byte_value == ppmfb_pkg::CH_LF) || (in_byte_value == ppmfb_pkg::CH_CR);
  assign dval = 4'(in_byte_value - ppmfb_pkg::CH_ZERO);

  always_comb begin
    cmt_e   = cmd.clear ? 1'b0 : cmt_r;
    num_e   = cmd.clear ? 1'b0 : num_r;
    bin_e   = cmd.clear ? 1'b0 : bin_r;
    acc_e   = cmd.clear ? '0 : acc_r;
    chan_e  = cmd.clear ? 2'd0 : chan_r;
    col_e   = cmd.clear ? '0 : col_r;
    row_e   = cmd.clear ? '0 : row_r;
    w_e     = cmd.clear ? '0 : w_r;
    h_e     = cmd.clear ? '0 : h_r;
    scale_e = cmd.clear ? 8'd1 : scale_r;
    red_e   = cmd.clear ? 8'd0 : red_r;
    grn_e   = cmd.clear ? 8'd0 : grn_r;

    mul10 = {acc_e, 3'b000} + {2'b00, acc_e, 1'b0} + {{AW{1'b0}}, dval};
    trial = {rem_r, 1'b1};
    smp = cmd.sample_bin ? in_byte_value : acc_e[7:0];
    sprod = smp * scale_e;
    sc = sprod[7:0];
    rowmul = row_e * fbw_r;
    addr = ppmfb_pkg::ADDR_W'(rowmul + MW'(col_e));
    word = {red_e, grn_e, sc};
    fb_hit = (CW'(col_e) < CW'(fbw_r)) && (CW'(row_e) < CW'(fbh_r));
    col1 = {1'b0, col_e} + 1'b1;
    row1 = {1'b0, row_e} + 1'b1;
    last = (row1 >= {1'b0, h_e}) && (col1 >= {1'b0, w_e});

    bin_nxt = bin_e; cmt_nxt = cmt_e; num_nxt = num_e; acc_nxt = acc_e;
    w_nxt = w_e; h_nxt = h_e; col_nxt = col_e; row_nxt = row_e;
    scale_nxt = scale_e; red_nxt = red_e; grn_nxt = grn_e; chan_nxt = chan_e;
    divd_nxt = divd_r; rem_nxt = rem_r;
    ov_nxt = ov_r && out_stall;
    ok_nxt = ok_r; oa_nxt = oa_r; op_nxt = op_r; oe_nxt = oe_r;

    if (cmd.magic_scan) begin
      if (cmt_e) begin
        if (nl) cmt_nxt = 1'b0;
      end else if (in_byte_value == ppmfb_pkg::CH_HASH) begin
        cmt_nxt = 1'b1;
      end
    end

    if (cmd.scan) begin
      if (cmt_e) begin
        if (nl) cmt_nxt = 1'b0;
      end else if (digit) begin
        acc_nxt = (mul10 > (AW+4)'({AW{1'b1}})) ? {AW{1'b1}} : AW'(mul10);
        num_nxt = 1'b1;
      end else begin
        acc_nxt = '0;
        num_nxt = 1'b0;
        if (in_byte_value == ppmfb_pkg::CH_HASH) cmt_nxt = 1'b1;
      end
    end

    if (cmd.set_bin) bin_nxt = cmd.bin_val;
    if (cmd.ld_width) w_nxt = acc_e[DW-1:0];
    if (cmd.ld_height) h_nxt = acc_e[DW-1:0];

    if (cmd.start_div) begin
      divd_nxt = acc_e[7:0];
      rem_nxt = 8'd0;
      scale_nxt = 8'd0;
    end
    if (cmd.raster_init) begin
      chan_nxt = 2'd0;
      col_nxt = '0;
      row_nxt = '0;
      if (bin_e) cmt_nxt = 1'b0;
    end
    if (cmd.div_step) begin
      if (trial >= {1'b0, divd_r}) begin
        rem_nxt = 8'(trial - {1'b0, divd_r});
        scale_nxt = {scale_r[6:0], 1'b1};
      end else begin
        rem_nxt = trial[7:0];
        scale_nxt = {scale_r[6:0], 1'b0};
      end
    end

    if (cmd.sample_bin || cmd.sample_tok) begin
      case (chan_e)
        2'd0: begin
          red_nxt = sc;
          chan_nxt = 2'd1;
        end
        2'd1: begin
          grn_nxt = sc;
          chan_nxt = 2'd2;
        end
        default: begin
          chan_nxt = 2'd0;
          if (col1 >= {1'b0, w_e}) begin
            col_nxt = '0;
            row_nxt = row1[DW-1:0];
          end else begin
            col_nxt = col1[DW-1:0];
          end
          if (last || fb_hit) begin
            ov_nxt = 1'b1;
            ok_nxt = last ? ppmfb_pkg::KIND_DONE : ppmfb_pkg::KIND_PIXEL;
            oa_nxt = fb_hit ? addr : 24'd0;
            op_nxt = fb_hit ? word : 24'd0;
            oe_nxt = ppmfb_pkg::ERR_NONE;
          end
        end
      endcase
    end

    if (cmd.emit_err || cmd.emit_done) begin
      ov_nxt = 1'b1;
      ok_nxt = cmd.emit_err ? ppmfb_pkg::KIND_ERROR : ppmfb_pkg::KIND_DONE;
      oa_nxt = 24'd0;
      op_nxt = 24'd0;
      oe_nxt = cmd.emit_err ? cmd.err_code : ppmfb_pkg::ERR_NONE;
    end
  end

  always_comb begin
    st.cmt = cmt_e;
    st.tok_end = !cmt_e && !digit && num_e;
    st.tok_big = {1'b0, acc_e} > (AW+1)'(MAX_DIM);
    st.tok_zero = (acc_e == '0);
    st.tok_over = (acc_e > AW'(ppmfb_pkg::FULL_SCALE));
    st.bin = bin_e;
    st.dims_zero = (w_r == '0) || (h_r == '0);
    st.last_px = (chan_e == 2'd2) && last;
    st.out_busy = ov_r && out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fbw_r <= ppmfb_pkg::FB_WIDTH_RST;
      fbh_r <= ppmfb_pkg::FB_HEIGHT_RST;
      bin_r <= 1'b0; cmt_r <= 1'b0; num_r <= 1'b0; acc_r <= '0;
      w_r <= '0; h_r <= '0; col_r <= '0; row_r <= '0;
      scale_r <= 8'd1; red_r <= 8'd0; grn_r <= 8'd0; chan_r <= 2'd0;
      ov_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == ppmfb_pkg::REG_FB_WIDTH) fbw_r <= cfg_data;
      if (cfg_we && cfg_index == ppmfb_pkg::REG_FB_HEIGHT) fbh_r <= cfg_data;
      bin_r <= bin_nxt; cmt_r <= cmt_nxt; num_r <= num_nxt; acc_r <= acc_nxt;
      w_r <= w_nxt; h_r <= h_nxt; col_r <= col_nxt; row_r <= row_nxt;
      scale_r <= scale_nxt; red_r <= red_nxt; grn_r <= grn_nxt; chan_r <= chan_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    divd_r <= divd_nxt;
    rem_r <= rem_nxt;
    ok_r <= ok_nxt;
    oa_r <= oa_nxt;
    op_r <= op_nxt;
    oe_r <= oe_nxt;
  end

  assign out_valid = ov_r;
  assign out_result_kind = ok_r;
  assign out_write_address = oa_r;
  assign out_pixel_word = op_r;
  assign out_error_code = oe_r;

endmodule

@@ design/ppm_stream_to_framebuffer.sv @@
// Top level of the PPM (P3/P6) byte-stream decoder with framebuffer write output.
// Takes one file byte per cycle and returns at most one word per byte: a pixel
// write, an image-complete word or a header error. The byte that ends the maxval
// token starts an 8-step restoring divider for 255/maxval; the input stalls
// while it runs and after it, also for zero width or height. Otherwise a byte is
// taken every cycle unless the output register holds a word that is stalled.
// The framebuffer width and height registers sit at index 0 and 1 of the cfg port.
module ppm_stream_to_framebuffer #(
  parameter int MAX_DIM = ppmfb_pkg::MAX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_start_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [23:0] out_write_address,
  output logic [23:0] out_pixel_word,
  output logic [2:0]  out_error_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  ppmfb_pkg::cmd_t    cmd;
  ppmfb_pkg::status_t st;

  assign cfg_ready = 1'b1;

  ppmfb_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_byte_value    (in_byte_value),
    .in_start_of_file (in_start_of_file),
    .in_stall         (in_stall),
    .st               (st),
    .cmd              (cmd)
  );

  ppmfb_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_byte_value     (in_byte_value),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .st                (st),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_result_kind   (out_result_kind),
    .out_write_address (out_write_address),
    .out_pixel_word    (out_pixel_word),
    .out_error_code    (out_error_code)
  );

endmodule
